@@ hw/rtl/lgpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// lgpsr_pkg: shared types and constants of the light gun pad responder
// Command codes, reply constants, position limits and the stage record that
// travels from the sequencing front end to the reply stage.
// ----------------------------------------------------------------------------
`default_nettype none

package lgpsr_pkg;

  // Host command codes
  localparam logic [7:0] CmdPoll   = 8'h42;
  localparam logic [7:0] CmdConfig = 8'h43;
  localparam logic [7:0] CmdStatus = 8'h45;
  localparam logic [7:0] CmdConstA = 8'h46;
  localparam logic [7:0] CmdConstB = 8'h47;
  localparam logic [7:0] CmdConstC = 8'h4C;
  localparam logic [7:0] CmdVibMap = 8'h4D;

  // Reply constants
  localparam logic [7:0] ModeConfig = 8'hF3;
  localparam logic [7:0] ModeGun    = 8'h63;
  localparam logic [7:0] HdrZero    = 8'h00;
  localparam logic [7:0] HdrTag     = 8'h5A;
  localparam logic [7:0] ReplyFill  = 8'hFF;

  // Byte positions within a transaction
  localparam logic [3:0] PosHdr0  = 4'd0;
  localparam logic [3:0] PosMode  = 4'd1;
  localparam logic [3:0] PosTag   = 4'd2;
  localparam logic [3:0] PosBtnHi = 4'd3;
  localparam logic [3:0] PosBtnLo = 4'd4;
  localparam logic [3:0] PosXLo   = 4'd5;
  localparam logic [3:0] PosXHi   = 4'd6;
  localparam logic [3:0] PosYLo   = 4'd7;
  localparam logic [3:0] PosYHi   = 4'd8;
  localparam logic [3:0] PosLast  = 4'd15;

  // Position scaling and limits
  localparam logic [9:0]  XOffset   = 10'd64;
  localparam logic [8:0]  WidthNtsc = 9'd378;
  localparam logic [8:0]  WidthPal  = 9'd385;
  localparam logic [9:0]  EdgeLow   = 10'd21;
  localparam logic [9:0]  EdgeHigh  = 10'd1002;
  localparam logic [15:0] OffX      = 16'h0001;
  localparam logic [15:0] OffY      = 16'h000A;

  // Configuration register indexes
  localparam logic [1:0] RegPalMode = 2'd0;
  localparam logic [1:0] RegYStart  = 2'd1;
  localparam logic [1:0] RegYLines  = 2'd2;

  // Configuration register values
  typedef struct packed {
    logic       pal_mode;
    logic [9:0] y_start;
    logic [9:0] y_lines;
  } cfg_t;

  // One accepted byte with the sequencing state it was handled under
  typedef struct packed {
    logic [3:0]  pos;
    logic [7:0]  cmd_latched;
    logic        cfg_mode;
    logic [15:0] button_word;
    logic [9:0]  aim_x;
    logic [9:0]  aim_y;
    logic        offscreen;
  } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/lgpsr_front.sv @@
// ----------------------------------------------------------------------------
// lgpsr_front: byte sequencer and input register
// Tracks byte position, latched command and config flag, and registers each
// accepted byte together with the state it is answered under.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpsr_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic                   advance_i,
  input  wire logic [7:0]             cmd_byte_i,
  input  wire logic                   first_byte_i,
  input  wire logic [15:0]            button_word_i,
  input  wire logic [9:0]             aim_x_i,
  input  wire logic [9:0]             aim_y_i,
  input  wire logic                   shoot_outside_i,
  input  wire logic                   screen_dark_i,
  output      logic                   valid_o,
  output      lgpsr_pkg::stage_t      stage_o
);

  logic [3:0]        count_q, count_d, pos;
  logic [7:0]        latched_q, latched_d;
  logic              cfg_act_q, cfg_act_d;
  logic              valid_q, valid_d;
  lgpsr_pkg::stage_t stage_q, stage_d;
  logic              off;

  // Clear position on first byte, then step and saturate
  assign pos = first_byte_i ? lgpsr_pkg::PosHdr0 : count_q;

  always_comb begin
    count_d   = count_q;
    latched_d = latched_q;
    cfg_act_d = cfg_act_q;
    if (accept_i) begin
      count_d = (pos == lgpsr_pkg::PosLast) ? pos : pos + 4'd1;
      if (pos == lgpsr_pkg::PosMode) begin
        latched_d = cmd_byte_i;
      end
      if (pos == lgpsr_pkg::PosBtnHi && latched_q == lgpsr_pkg::CmdConfig) begin
        cfg_act_d = (cmd_byte_i != 8'd0);
      end
    end
  end

  // Flag offscreen aim
  assign off = shoot_outside_i || screen_dark_i ||
               (aim_x_i < lgpsr_pkg::EdgeLow) || (aim_x_i > lgpsr_pkg::EdgeHigh) ||
               (aim_y_i < lgpsr_pkg::EdgeLow) || (aim_y_i > lgpsr_pkg::EdgeHigh);

  // Capture the transaction with its state
  always_comb begin
    stage_d             = stage_q;
    valid_d             = valid_q;
    if (accept_i) begin
      stage_d.pos         = pos;
      stage_d.cmd_latched = latched_q;
      stage_d.cfg_mode    = cfg_act_q;
      stage_d.button_word = button_word_i;
      stage_d.aim_x       = aim_x_i;
      stage_d.aim_y       = aim_y_i;
      stage_d.offscreen   = off;
      valid_d             = 1'b1;
    end else if (advance_i) begin
      valid_d             = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      latched_q <= '0;
      cfg_act_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      latched_q <= latched_d;
      cfg_act_q <= cfg_act_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

@@ hw/rtl/lgpsr_aim.sv @@
// ----------------------------------------------------------------------------
// lgpsr_aim: aim to position scaling
// Scales aim by display width and height, adds offsets, clamps Y to one and
// substitutes the offscreen report.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpsr_aim (
  input  wire logic              pal_mode_i,
  input  wire logic [9:0]        y_start_i,
  input  wire logic [9:0]        y_lines_i,
  input  wire logic [9:0]        aim_x_i,
  input  wire logic [9:0]        aim_y_i,
  input  wire logic              offscreen_i,
  output      logic [15:0]       pos_x_o,
  output      logic [15:0]       pos_y_o
);

  logic [8:0]  width;
  logic [18:0] prod_x;
  logic [19:0] prod_y;
  logic [9:0]  x_sum;
  logic [10:0] y_sum;

  assign width  = pal_mode_i ? lgpsr_pkg::WidthPal : lgpsr_pkg::WidthNtsc;
  assign prod_x = width * aim_x_i;
  assign prod_y = y_lines_i * aim_y_i;

  // X never drops below the offset, so it needs no clamp
  assign x_sum = lgpsr_pkg::XOffset + {1'b0, prod_x[18:10]};
  assign y_sum = {1'b0, y_start_i} + {1'b0, prod_y[19:10]};

  always_comb begin
    if (offscreen_i) begin
      pos_x_o = lgpsr_pkg::OffX;
      pos_y_o = lgpsr_pkg::OffY;
    end else begin
      pos_x_o = {6'd0, x_sum};
      pos_y_o = (y_sum == 11'd0) ? 16'd1 : {5'd0, y_sum};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lgpsr_reply.sv @@
// ----------------------------------------------------------------------------
// lgpsr_reply: reply selection and output register
// Picks the reply byte for the registered position and command and holds it
// until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lgpsr_reply (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic              taken_i,
  input  wire lgpsr_pkg::stage_t stage_i,
  input  wire logic [15:0]       pos_x_i,
  input  wire logic [15:0]       pos_y_i,
  output      logic              valid_o,
  output      logic [7:0]        reply_o
);

  logic [7:0] reply_d, reply_q, poll_byte;
  logic       valid_d, valid_q;

  // Poll report bytes by position
  always_comb begin
    unique case (stage_i.pos)
      lgpsr_pkg::PosBtnHi: poll_byte = stage_i.button_word[15:8];
      lgpsr_pkg::PosBtnLo: poll_byte = stage_i.button_word[7:0];
      lgpsr_pkg::PosXLo:   poll_byte = pos_x_i[7:0];
      lgpsr_pkg::PosXHi:   poll_byte = pos_x_i[15:8];
      lgpsr_pkg::PosYLo:   poll_byte = pos_y_i[7:0];
      lgpsr_pkg::PosYHi:   poll_byte = pos_y_i[15:8];
      default:             poll_byte = 8'd0;
    endcase
  end

  // Header bytes first, then the latched command decides
  always_comb begin
    unique case (stage_i.pos)
      lgpsr_pkg::PosHdr0: reply_d = lgpsr_pkg::HdrZero;
      lgpsr_pkg::PosMode: reply_d = stage_i.cfg_mode ? lgpsr_pkg::ModeConfig
                                                     : lgpsr_pkg::ModeGun;
      lgpsr_pkg::PosTag:  reply_d = lgpsr_pkg::HdrTag;
      default: begin
        unique case (stage_i.cmd_latched)
          lgpsr_pkg::CmdPoll:   reply_d = poll_byte;
          lgpsr_pkg::CmdConfig: reply_d = lgpsr_pkg::ReplyFill;
          lgpsr_pkg::CmdVibMap: reply_d = lgpsr_pkg::ReplyFill;
          lgpsr_pkg::CmdStatus,
          lgpsr_pkg::CmdConstA,
          lgpsr_pkg::CmdConstB,
          lgpsr_pkg::CmdConstC: reply_d = 8'd0;
          default:              reply_d = 8'd0;
        endcase
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (taken_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      reply_q <= reply_d;
    end
  end

  assign valid_o = valid_q;
  assign reply_o = reply_q;

endmodule

`default_nettype wire

@@ hw/rtl/lightgun_pad_serial_responder.sv @@
// ----------------------------------------------------------------------------
// lightgun_pad_serial_responder: light gun pad serial reply generator
// Path to the reply: input register, then result register. Throughput: one
// byte per cycle when the reply side is not stalled, set by the single pass
// from the input register through the two scaling multiplies to the result.
// Reset: byte position, latched command and config flag clear; registers
// return to NTSC width, first line 25 and height 240.
// ----------------------------------------------------------------------------
`default_nettype none

module lightgun_pad_serial_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [9:0]  cfg_data_i,
  // Command stream
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [7:0] cmd_byte, [23:8] button_word, [33:24] aim_x, [43:34] aim_y,
  // [44] shoot_outside, [45] screen_dark, [47:46] zero
  input  wire logic [47:0] s_axis_tdata_i,
  // [0] first_byte
  input  wire logic        s_axis_tuser_i,
  // Reply stream
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] reply_byte
  output      logic [7:0]  m_axis_tdata_o
);

  lgpsr_pkg::cfg_t   cfg_q, cfg_d;
  lgpsr_pkg::stage_t stage;
  logic              st_valid, advance, accept;
  logic [15:0]       pos_x, pos_y;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgpsr_pkg::RegPalMode: cfg_d.pal_mode = cfg_data_i[0];
        lgpsr_pkg::RegYStart:  cfg_d.y_start  = cfg_data_i;
        lgpsr_pkg::RegYLines:  cfg_d.y_lines  = cfg_data_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pal_mode <= 1'b0;
      cfg_q.y_start  <= 10'd25;
      cfg_q.y_lines  <= 10'd240;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline flow control
  assign advance         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = !st_valid || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  lgpsr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .advance_i       (advance),
    .cmd_byte_i      (s_axis_tdata_i[7:0]),
    .first_byte_i    (s_axis_tuser_i),
    .button_word_i   (s_axis_tdata_i[23:8]),
    .aim_x_i         (s_axis_tdata_i[33:24]),
    .aim_y_i         (s_axis_tdata_i[43:34]),
    .shoot_outside_i (s_axis_tdata_i[44]),
    .screen_dark_i   (s_axis_tdata_i[45]),
    .valid_o         (st_valid),
    .stage_o         (stage)
  );

  lgpsr_aim u_aim (
    .pal_mode_i  (cfg_q.pal_mode),
    .y_start_i   (cfg_q.y_start),
    .y_lines_i   (cfg_q.y_lines),
    .aim_x_i     (stage.aim_x),
    .aim_y_i     (stage.aim_y),
    .offscreen_i (stage.offscreen),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y)
  );

  lgpsr_reply u_reply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (st_valid && advance),
    .taken_i (m_axis_tready_i),
    .stage_i (stage),
    .pos_x_i (pos_x),
    .pos_y_i (pos_y),
    .valid_o (m_axis_tvalid_o),
    .reply_o (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ dv/lightgun_pad_serial_responder_tb.sv @@
// ----------------------------------------------------------------------------
// lightgun_pad_serial_responder_tb: self-checking bench for the pad responder
// Drives host command bytes on the input stream and predicts each reply byte
// with a cycle-free model of the header, poll, config and fill replies. The
// bench opens with a directed table, then runs random pad exchanges under
// several display settings. Both stream sides idle at random outside the steady phase.
// ----------------------------------------------------------------------------

module lightgun_pad_serial_responder_tb;

  import lgpsr_pkg::*;

  // Register index that selects no register
  localparam logic [1:0] RegNone = 2'd3;
  localparam int unsigned StallLimit = 2000;

  // One host byte with its side-band inputs; known/want pin the reply
  typedef struct packed {
    logic        first;
    logic [7:0]  cmd;
    logic [15:0] buttons;
    logic [9:0]  ax;
    logic [9:0]  ay;
    logic        shoot;
    logic        dark;
    logic        known;
    logic [7:0]  want;
  } host_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = RegPalMode;
  logic [9:0]  cfg_data = 10'd0;
  logic        s_valid = 1'b0;
  logic [47:0] s_tdata = 48'd0;
  logic        s_tuser = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;

  // Prediction state: display settings and exchange sequencing
  logic        pal_sel = 1'b0;
  logic [9:0]  first_line = 10'd25;
  logic [9:0]  line_count = 10'd240;
  logic [3:0]  pos_exp = PosHdr0;
  logic [7:0]  cmd_exp = 8'h00;
  logic        cfg_mode_exp = 1'b0;

  logic [7:0]  replies_due [$];
  logic [7:0]  head_reply;
  logic        steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  host_byte_t  directed_rows [30];

  always #4 clk_i = ~clk_i;

  lightgun_pad_serial_responder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h, expected %02h", what, got, want);
    mismatches++;
  endtask

  // Compute the reply to one host byte and advance the sequencing state
  function automatic logic [7:0] reply_for_byte(input host_byte_t b);
    logic [7:0]  reply;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] wide;
    if (b.first) pos_exp = PosHdr0;
    px = OffX;
    py = OffY;
    if (!(b.shoot || b.dark || b.ax < EdgeLow || b.ax > EdgeHigh ||
          b.ay < EdgeLow || b.ay > EdgeHigh)) begin
      wide = 32'(XOffset) + ((32'(pal_sel ? WidthPal : WidthNtsc) * 32'(b.ax)) >> 10);
      px = (wide < 1) ? 16'd1 : wide[15:0];
      wide = 32'(first_line) + ((32'(line_count) * 32'(b.ay)) >> 10);
      py = (wide < 1) ? 16'd1 : wide[15:0];
    end
    case (pos_exp)
      PosHdr0: reply = HdrZero;
      PosMode: begin
        cmd_exp = b.cmd;
        reply = cfg_mode_exp ? ModeConfig : ModeGun;
      end
      PosTag: reply = HdrTag;
      default: begin
        case (cmd_exp)
          CmdPoll: begin
            case (pos_exp)
              PosBtnHi: reply = b.buttons[15:8];
              PosBtnLo: reply = b.buttons[7:0];
              PosXLo:   reply = px[7:0];
              PosXHi:   reply = px[15:8];
              PosYLo:   reply = py[7:0];
              PosYHi:   reply = py[15:8];
              default:  reply = HdrZero;
            endcase
          end
          CmdConfig: begin
            // Only the first payload byte moves the config flag
            if (pos_exp == PosBtnHi) cfg_mode_exp = (b.cmd != 8'h00);
            reply = ReplyFill;
          end
          CmdVibMap: reply = ReplyFill;
          default:   reply = HdrZero;
        endcase
      end
    endcase
    if (pos_exp != PosLast) pos_exp = pos_exp + 4'd1;
    return reply;
  endfunction

  // Present one byte, hold it until taken, then queue its reply
  task automatic send_byte(input host_byte_t b);
    logic [7:0] predicted;
    if (!steady && $urandom_range(99) < 28) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tdata <= {2'b00, b.dark, b.shoot, b.ay, b.ax, b.buttons, b.cmd};
    s_tuser <= b.first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = reply_for_byte(b);
    replies_due.push_back(b.known ? b.want : predicted);
  endtask

  // Drop the input stream and let every pending reply drain
  task automatic settle();
    s_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all display registers plus one stray index while idle
  task automatic program_regs(input logic pal, input logic [9:0] ys,
                              input logic [9:0] yl);
    logic [1:0] regs [4];
    logic [9:0] vals [4];
    regs = '{RegPalMode, RegNone, RegYStart, RegYLines};
    vals = '{{9'($urandom), pal}, 10'($urandom), ys, yl};
    settle();
    for (int k = 0; k < 4; k++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[k];
      cfg_data <= vals[k];
      @(posedge clk_i);
      case (regs[k])
        RegPalMode: pal_sel = vals[k][0];
        RegYStart:  first_line = vals[k];
        RegYLines:  line_count = vals[k];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [9:0] pick_aim();
    case ($urandom_range(9))
      0: return 10'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return EdgeLow - 10'd1;
          1: return EdgeLow;
          2: return EdgeHigh;
          default: return EdgeHigh + 10'd1;
        endcase
      end
      default: return 10'($urandom_range(EdgeLow, EdgeHigh));
    endcase
  endfunction

  // Random pad exchanges: mostly well-formed, with stray start flags
  task automatic run_exchanges(input int n_items);
    host_byte_t  b;
    logic [7:0]  op;
    int          len;
    int          sent;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45)      op = CmdPoll;
      else if (pick < 57) op = CmdConfig;
      else if (pick < 63) op = CmdStatus;
      else if (pick < 67) op = CmdConstA;
      else if (pick < 71) op = CmdConstB;
      else if (pick < 75) op = CmdConstC;
      else if (pick < 85) op = CmdVibMap;
      else                op = 8'($urandom);
      if ($urandom_range(9) == 0) len = $urandom_range(16, 22);
      else if (op == CmdPoll) len = $urandom_range(8, 10);
      else len = $urandom_range(1, 8);
      for (int k = 0; k < len && sent < n_items; k++) begin
        b.first   = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
        b.cmd     = 8'($urandom);
        if (k == 1) b.cmd = op;
        if (k == 3 && op == CmdConfig && $urandom_range(1) == 0) b.cmd = 8'h00;
        b.buttons = 16'($urandom);
        b.ax      = pick_aim();
        b.ay      = pick_aim();
        b.shoot   = ($urandom_range(15) == 0);
        b.dark    = ($urandom_range(15) == 0);
        b.known   = 1'b0;
        b.want    = 8'h00;
        send_byte(b);
        sent++;
      end
    end
  endtask

  // Reply side: random back-pressure, compare, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_ready <= steady || ($urandom_range(99) >= 36);
      if (m_axis_tvalid_o && m_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with nothing pending", m_axis_tdata_o, 8'h00);
        end else begin
          head_reply = replies_due.pop_front();
          if (m_axis_tdata_o !== head_reply)
            report_mismatch("reply byte", m_axis_tdata_o, head_reply);
        end
      end
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    // first, cmd, buttons, ax, ay, shoot, dark, known, want
    directed_rows = '{
      // poll under reset settings, offscreen position forms
      '{1'b1, 8'hFF, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, HdrZero},
      '{1'b0, CmdPoll, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, ModeGun},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, HdrTag},
      '{1'b0, 8'h00, 16'hFFFF, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, 8'hFF},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, 8'h00},
      '{1'b0, 8'h00, 16'h0000, 10'd1023, 10'd512, 1'b1, 1'b0, 1'b1, 8'h01},
      '{1'b0, 8'h00, 16'h0000, 10'd20, 10'd512, 1'b0, 1'b0, 1'b1, 8'h00},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b1, 1'b1, 8'h0A},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd1023, 1'b0, 1'b0, 1'b1, 8'h00},
      '{1'b0, 8'h00, 16'hFFFF, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, HdrZero},
      // enter config mode, fill continues past the first payload byte
      '{1'b1, 8'h01, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, HdrZero},
      '{1'b0, CmdConfig, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ModeGun},
      '{1'b0, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, HdrTag},
      '{1'b0, 8'h01, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ReplyFill},
      '{1'b0, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ReplyFill},
      // poll in config mode with aim on the visible edges
      '{1'b1, 8'h00, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, HdrZero},
      '{1'b0, CmdPoll, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, ModeConfig},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, HdrTag},
      '{1'b0, 8'h00, 16'h5AA5, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, 8'h5A},
      '{1'b0, 8'h00, 16'h5AA5, 10'd512, 10'd512, 1'b0, 1'b0, 1'b1, 8'hA5},
      '{1'b0, 8'h00, 16'h0000, 10'd21, 10'd1002, 1'b0, 1'b0, 1'b0, 8'h00},
      '{1'b0, 8'h00, 16'h0000, 10'd1002, 10'd21, 1'b0, 1'b0, 1'b0, 8'h00},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd1002, 1'b0, 1'b0, 1'b0, 8'h00},
      '{1'b0, 8'h00, 16'h0000, 10'd512, 10'd21, 1'b0, 1'b0, 1'b0, 8'h00},
      // leave config mode, then a status request
      '{1'b1, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, HdrZero},
      '{1'b0, CmdConfig, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ModeConfig},
      '{1'b0, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, HdrTag},
      '{1'b0, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ReplyFill},
      '{1'b1, 8'h00, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, HdrZero},
      '{1'b0, CmdStatus, 16'h0000, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, ModeGun}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    run_exchanges(200);

    // Sweep the display settings, extremes first
    program_regs(1'b1, 10'd0, 10'd1023);
    run_exchanges(230);
    program_regs(1'b0, 10'd1023, 10'd0);
    steady <= 1'b1;
    run_exchanges(230);
    steady <= 1'b0;
    program_regs(1'b1, 10'd0, 10'd0);
    run_exchanges(230);
    program_regs(1'($urandom), 10'($urandom), 10'($urandom));
    run_exchanges(230);

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
